/* design/swm_pkg.sv */
// Shared types and constants for the sliding-window median filter.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int CFG_W        = 7;
    localparam int RESET_WINDOW = 3;

    typedef struct packed {
        logic load;
        logic remove;
        logic valid;
        logic wvalid;
    } swm_ctl_t;

endpackage

/* design/sliding_window_median_top.sv */
// Top level of the streaming sliding-window median filter.
// Samples arrive on the slave stream: tdata carries the signed sample and
// tuser carries the restart flag, which empties the window before the sample
// enters. Medians leave on the master stream as signed values in tdata.
// The window length is written through cfg_we and cfg_wdata; the user must
// do so only while the block is idle, which the block does not enforce.
// A write also empties the window. Zero acts as one, and a length above
// MAX_WINDOW acts as MAX_WINDOW. No median is produced until the window
// holds window_length samples; from then on every sample yields one median,
// the lower of the two middle values for an even length.
// One sample is accepted per cycle while s_tready is high. The chain of
// sorted cells inserts the sample and evicts the oldest one in the accept
// cycle; the middle cell is then selected into the output register.
// After reset the window is empty and its length is three. When the receiver
// stalls, one median waits in the output register and one more in the cell
// chain; s_tready then falls until the output register drains.
`timescale 1ns / 1ps

module sliding_window_median_top #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // sample
    input  logic                                     s_tuser,   // restart
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,  // median
    input  logic                                     cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]                cfg_wdata
);
    import swm_pkg::*;

    localparam int SW      = SAMPLE_WIDTH;
    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW      = $clog2(MAX_WINDOW + 1);
    localparam int K_RESET = (RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW : RESET_WINDOW;

    logic [CW-1:0]        k_reg;
    logic [CW-1:0]        fill_reg;
    logic                 pend_reg;
    logic                 out_valid_reg;
    logic [SW-1:0]        median_reg;

    logic                 accept;
    logic                 load_out;
    logic [CW-1:0]        fill_eff;
    logic                 full;
    logic [CW-1:0]        kept;
    logic [CW-1:0]        fill_new;
    logic                 produce;
    logic [CW-1:0]        k_wr;
    logic [AW-1:0]        oldest_age;
    logic [AW-1:0]        med_idx;
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] o;

    logic signed [SW-1:0] cell_v    [MAX_WINDOW];
    logic                 cell_gt   [MAX_WINDOW];
    logic [AW-1:0]        cell_age  [MAX_WINDOW];
    logic signed [SW-1:0] cell_w    [MAX_WINDOW];
    logic [AW-1:0]        cell_wage [MAX_WINDOW];
    logic                 cell_big  [MAX_WINDOW];
    logic                 cell_old  [MAX_WINDOW];
    swm_ctl_t             cell_ctl  [MAX_WINDOW];

    assign x        = $signed(s_tdata[SW-1:0]);
    assign load_out = pend_reg && (!out_valid_reg || m_tready);
    assign s_tready = !pend_reg || load_out;
    assign accept   = s_tvalid && s_tready;

    assign fill_eff   = s_tuser ? '0 : fill_reg;
    assign full       = (fill_eff == k_reg);
    assign kept       = full ? (k_reg - CW'(1)) : fill_eff;
    assign fill_new   = kept + CW'(1);
    assign produce    = (fill_new == k_reg);
    assign oldest_age = AW'(k_reg - CW'(1));
    assign med_idx    = AW'((k_reg - CW'(1)) >> 1);

    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            k_wr = CW'(1);
        end
        else if (int'(cfg_wdata) > MAX_WINDOW)
        begin
            k_wr = CW'(MAX_WINDOW);
        end
        else
        begin
            k_wr = CW'(cfg_wdata);
        end
    end

    // The oldest held sample is the one cell whose age has reached K-1.
    always_comb
    begin
        o = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (cell_old[i])
            begin
                o = o | cell_v[i];
            end
        end
    end

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_chain
        logic signed [SW-1:0] r_v;
        logic                 r_gt;
        logic [AW-1:0]        r_age;
        logic signed [SW-1:0] l_w;
        logic [AW-1:0]        l_wage;
        logic                 l_big;

        if (i < MAX_WINDOW - 1)
        begin : g_right
            assign r_v   = cell_v[i+1];
            assign r_gt  = cell_gt[i+1];
            assign r_age = cell_age[i+1];
        end
        else
        begin : g_right_end
            assign r_v   = '0;
            assign r_gt  = 1'b0;
            assign r_age = '0;
        end

        if (i > 0)
        begin : g_left
            assign l_w    = cell_w[i-1];
            assign l_wage = cell_wage[i-1];
            assign l_big  = cell_big[i-1];
        end
        else
        begin : g_left_end
            assign l_w    = '0;
            assign l_wage = '0;
            assign l_big  = 1'b0;
        end

        assign cell_ctl[i].load   = accept;
        assign cell_ctl[i].remove = full;
        assign cell_ctl[i].valid  = (fill_eff > CW'(i));
        assign cell_ctl[i].wvalid = (kept > CW'(i));

        swm_cell #(
            .SW (SW),
            .AW (AW)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[i]),
            .x          (x),
            .o          (o),
            .oldest_age (oldest_age),
            .r_v        (r_v),
            .r_gt       (r_gt),
            .r_age      (r_age),
            .l_w        (l_w),
            .l_wage     (l_wage),
            .l_big      (l_big),
            .v          (cell_v[i]),
            .gt         (cell_gt[i]),
            .age        (cell_age[i]),
            .w          (cell_w[i]),
            .wage       (cell_wage[i]),
            .big        (cell_big[i]),
            .is_oldest  (cell_old[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= CW'(K_RESET);
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                k_reg    <= k_wr;
                fill_reg <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_new;
            end

            if (accept)
            begin
                pend_reg <= produce;
            end
            else if (load_out)
            begin
                pend_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            median_reg <= cell_v[med_idx];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(median_reg);

endmodule

/* design/swm_cell.sv */
// One sorted cell of the median chain, holding a sample and its age.
`timescale 1ns / 1ps

module swm_cell #(
    parameter int SW = 32,
    parameter int AW = 6
) (
    input  logic                 clk,
    input  swm_pkg::swm_ctl_t    ctl,
    input  logic signed [SW-1:0] x,
    input  logic signed [SW-1:0] o,
    input  logic [AW-1:0]        oldest_age,
    input  logic signed [SW-1:0] r_v,
    input  logic                 r_gt,
    input  logic [AW-1:0]        r_age,
    input  logic signed [SW-1:0] l_w,
    input  logic [AW-1:0]        l_wage,
    input  logic                 l_big,
    output logic signed [SW-1:0] v,
    output logic                 gt,
    output logic [AW-1:0]        age,
    output logic signed [SW-1:0] w,
    output logic [AW-1:0]        wage,
    output logic                 big,
    output logic                 is_oldest
);
    import swm_pkg::*;

    logic signed [SW-1:0] v_reg;
    logic signed [SW-1:0] v_next;
    logic [AW-1:0]        age_reg;
    logic [AW-1:0]        age_next;
    logic                 shift_out;
    logic                 wgt;

    assign v         = v_reg;
    assign age       = age_reg;
    assign gt        = (v_reg > x);
    assign is_oldest = ctl.valid && (age_reg == oldest_age);

    // Cells valued >= the evicted sample take their right neighbour's content.
    assign shift_out = ctl.remove && ctl.valid && (v_reg >= o);
    assign w         = shift_out ? r_v : v_reg;
    assign wage      = shift_out ? r_age : age_reg;
    assign wgt       = shift_out ? r_gt : gt;
    assign big       = !ctl.wvalid || wgt;

    always_comb
    begin
        if (!big)
        begin
            v_next   = w;
            age_next = wage + AW'(1);
        end
        else if (!l_big)
        begin
            v_next   = x;
            age_next = '0;
        end
        else
        begin
            v_next   = l_w;
            age_next = l_wage + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            v_reg   <= v_next;
            age_reg <= age_next;
        end
    end

endmodule

/* design/swm_checker.sv */
// Port-level assertions for the sliding-window median filter, bound to the top level.
`timescale 1ns / 1ps

module swm_checker #(
    parameter int TDATA_W = 32
) (
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // A stalled median stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("median withdrawn while stalled");

    // A stalled median keeps its value.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("median changed while stalled");

    // With the output register empty, the block always takes a sample.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("sample refused while output register is empty");

    // A fresh median follows a sample transaction via the cells and output register.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("median appeared without a preceding sample transaction");

endmodule

bind sliding_window_median_top swm_checker #(.TDATA_W(TDATA_W)) u_swm_checker (.*);
